### rtl/rbss_pkg.sv
// Shared types, widths and constants of the ring buffer sample statistics block.
package rbss_pkg;

   // Field widths
   localparam int TEMP_W      = 12;
   localparam int VALUE_W     = 7;
   localparam int COUNT_W     = 16;
   localparam int SUM_OUT_W   = 13;
   localparam int MEAN_W      = 15;
   localparam int DUTY_W      = 8;
   localparam int CFG_W       = 7;

   // Ring sizing and register reset
   localparam int DEFAULT_MAX_DEPTH = 64;
   localparam int VALUE_MAX         = 127;
   localparam logic [CFG_W-1:0] RING_LENGTH_RESET = CFG_W'(50);

   // Saturation limits
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam int SUM_OUT_MAX = 8191;
   localparam int MEAN_MAX    = 32767;
   localparam int DUTY_MAX    = 255;

   // Mean has 8 fraction bits
   localparam int MEAN_FRAC = 8;

   // Duty = temp_q4 * 255 / 960, which reduces exactly to temp_q4 * 17 / 64
   localparam int PWM_MUL   = 17;
   localparam int PWM_SHIFT = 6;
   localparam int PWM_PROD_W = 16;

   // One classified sample travelling from the front end to the back end
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [DUTY_W-1:0]  duty;
   } item_type;

   // Back end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OLD,
      ST_PREV,
      ST_DIV,
      ST_DONE
   } back_state_type;

endpackage

### rtl/ring_buffer_sample_statistics_top.sv
// Ring buffer sample statistics: top level with the ring length register.
//
// Usage: each req_ beat carries one temperature sample (degrees C times 16).
// Each sample gives exactly one rsp_ beat: the stored integer value, the
// entry before it in the ring, reading and overwrite counts, the ring sum,
// the mean over the filled entries (8 fraction bits) and a PWM duty.
// The csr_ channel writes the ring length (1..MAX_DEPTH, clamped); write it
// only while no sample is in flight. It takes effect on the next sample.
// A sample passes from the two-beat queue through the back end states
// ST_IDLE, ST_OLD, ST_PREV, ST_DIV and ST_DONE into the result register.
// The serial restoring divider for the mean produces one quotient bit
// per cycle, and one sample is processed at a time, so the back end takes
// a new sample only once the last one has left ST_DONE.
// A two-beat queue sits in front of the back end, so samples are accepted
// while a result waits. When the receiver stalls the result register holds,
// the back end waits in its final step and the queue fills, then req_ready
// drops. Reset clears the ring (per-entry valid flags), counters, sum and
// write position and sets the ring length to 50; no clearing pass is needed.
module ring_buffer_sample_statistics_top import rbss_pkg::*; #(
   parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CFG_W-1:0]     csr_ring_length,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TEMP_W-1:0]    req_temp_q4,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VALUE_W-1:0]   rsp_current_value,
   output logic [VALUE_W-1:0]   rsp_previous_value,
   output logic [COUNT_W-1:0]   rsp_reading_count,
   output logic [COUNT_W-1:0]   rsp_overwrite_count,
   output logic [SUM_OUT_W-1:0] rsp_window_sum,
   output logic [MEAN_W-1:0]    rsp_window_mean_q8,
   output logic [DUTY_W-1:0]    rsp_pwm_duty
);

   logic [CFG_W-1:0] ring_length_ff, ring_length_in;
   logic             q_valid;
   item_type         q_item;
   logic             q_pop;

   // Ring length register, always ready for a beat
   assign csr_ready      = 1'b1;
   assign ring_length_in = (csr_valid && csr_ready) ? csr_ring_length : ring_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_length_ff <= RING_LENGTH_RESET;
      end else begin
         ring_length_ff <= ring_length_in;
      end
   end

   // Accept and classify samples
   rbss_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_temp_q4 (req_temp_q4),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   // Ring update, statistics and result register
   rbss_back #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .ring_length         (ring_length_ff),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_current_value   (rsp_current_value),
      .rsp_previous_value  (rsp_previous_value),
      .rsp_reading_count   (rsp_reading_count),
      .rsp_overwrite_count (rsp_overwrite_count),
      .rsp_window_sum      (rsp_window_sum),
      .rsp_window_mean_q8  (rsp_window_mean_q8),
      .rsp_pwm_duty        (rsp_pwm_duty)
   );

endmodule

### rtl/rbss_ram.sv
// Generic single write port RAM with one registered read port.
module rbss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rbss_front.sv
// Front end: accepts samples, classifies them and queues them for the back end.
module rbss_front import rbss_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [TEMP_W-1:0] req_temp_q4,
   output logic              q_valid,
   output item_type          q_item,
   input  logic              q_pop
);

   item_type              slot_ff [2];
   logic                  head_ff, head_in;
   logic                  tail_ff, tail_in;
   logic [1:0]            fill_ff, fill_in;
   item_type              cls_item;
   logic                  negative;
   logic [PWM_PROD_W-1:0] pwm_prod;
   logic [PWM_PROD_W-1:0] pwm_duty_wide;
   logic                  push;

   // Classify: clamp negatives to zero, take the integer part, scale and saturate the duty
   always_comb begin
      negative       = req_temp_q4[TEMP_W-1];
      pwm_prod       = PWM_PROD_W'(req_temp_q4[TEMP_W-2:0]) * PWM_PROD_W'(PWM_MUL);
      pwm_duty_wide  = pwm_prod >> PWM_SHIFT;
      cls_item.value = negative ? '0 : req_temp_q4[TEMP_W-2:4];
      if (negative) begin
         cls_item.duty = '0;
      end else if (pwm_duty_wide > PWM_PROD_W'(DUTY_MAX)) begin
         cls_item.duty = DUTY_W'(DUTY_MAX);
      end else begin
         cls_item.duty = pwm_duty_wide[DUTY_W-1:0];
      end
   end

   // Two-entry queue control
   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = slot_ff[head_ff];

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (push) begin
         tail_in = ~tail_ff;
      end
      if (q_pop && q_valid) begin
         head_in = ~head_ff;
      end
      case ({push, q_pop && q_valid})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 1'b0;
         tail_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // Store the classified beat
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= cls_item;
      end
   end

endmodule

### rtl/rbss_back.sv
// Back end: ring update, running sum, counters, serial mean divider and result register.
module rbss_back import rbss_pkg::*; #(
   parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CFG_W-1:0]   ring_length,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VALUE_W-1:0]   rsp_current_value,
   output logic [VALUE_W-1:0]   rsp_previous_value,
   output logic [COUNT_W-1:0]   rsp_reading_count,
   output logic [COUNT_W-1:0]   rsp_overwrite_count,
   output logic [SUM_OUT_W-1:0] rsp_window_sum,
   output logic [MEAN_W-1:0]    rsp_window_mean_q8,
   output logic [DUTY_W-1:0]    rsp_pwm_duty
);

   localparam int POS_W  = $clog2(MAX_DEPTH);
   localparam int LEN_W  = $clog2(MAX_DEPTH + 1);
   localparam int SUM_W  = $clog2(MAX_DEPTH * VALUE_MAX + 1);
   localparam int DIV_W  = SUM_W + MEAN_FRAC;
   localparam int STEP_W = $clog2(DIV_W + 1);

   back_state_type       state_ff, state_in;
   logic [POS_W-1:0]     wp_ff, wp_in;
   logic [COUNT_W-1:0]   readings_ff, readings_in;
   logic [COUNT_W-1:0]   overwrites_ff, overwrites_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [MAX_DEPTH-1:0] filled_ff, filled_in;
   logic                 out_valid_ff, out_valid_in;

   item_type             item_ff, item_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [POS_W-1:0]     prev_idx_ff, prev_idx_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     n_ff, n_in;
   logic [VALUE_W-1:0]   prev_ff, prev_in;
   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [STEP_W-1:0]    step_ff, step_in;

   logic [VALUE_W-1:0]   out_cur_ff, out_cur_in;
   logic [VALUE_W-1:0]   out_prev_ff, out_prev_in;
   logic [COUNT_W-1:0]   out_rd_ff, out_rd_in;
   logic [COUNT_W-1:0]   out_ow_ff, out_ow_in;
   logic [SUM_OUT_W-1:0] out_sum_ff, out_sum_in;
   logic [MEAN_W-1:0]    out_mean_ff, out_mean_in;
   logic [DUTY_W-1:0]    out_duty_ff, out_duty_in;

   logic [LEN_W-1:0]     len_clamped;
   logic [POS_W-1:0]     pos_calc;
   logic [POS_W-1:0]     prev_calc;
   logic [LEN_W-1:0]     pos_plus;
   logic [VALUE_W-1:0]   old_value;
   logic [COUNT_W-1:0]   readings_next;
   logic [LEN_W:0]       rem_shift;
   logic                 ram_we;
   logic [POS_W-1:0]     ram_waddr;
   logic [POS_W-1:0]     ram_raddr;
   logic [VALUE_W-1:0]   ram_rdata;

   // Sample ring storage
   rbss_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (item_ff.value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Effective length and the slot the next sample goes to
   always_comb begin
      if (32'(ring_length) > MAX_DEPTH) begin
         len_clamped = LEN_W'(MAX_DEPTH);
      end else if (ring_length == '0) begin
         len_clamped = LEN_W'(1);
      end else begin
         len_clamped = LEN_W'(ring_length);
      end
      pos_calc  = (LEN_W'(wp_ff) >= len_clamped) ? '0 : wp_ff;
      prev_calc = (pos_calc == '0) ? POS_W'(len_clamped - LEN_W'(1)) : pos_calc - POS_W'(1);
   end

   // Sequencer: next state, datapath and result register loads
   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      readings_in   = readings_ff;
      overwrites_in = overwrites_ff;
      sum_in        = sum_ff;
      filled_in     = filled_ff;
      out_valid_in  = out_valid_ff;
      item_in       = item_ff;
      pos_in        = pos_ff;
      prev_idx_in   = prev_idx_ff;
      len_in        = len_ff;
      n_in          = n_ff;
      prev_in       = prev_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      out_cur_in    = out_cur_ff;
      out_prev_in   = out_prev_ff;
      out_rd_in     = out_rd_ff;
      out_ow_in     = out_ow_ff;
      out_sum_in    = out_sum_ff;
      out_mean_in   = out_mean_ff;
      out_duty_in   = out_duty_ff;
      q_pop         = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = pos_ff;
      ram_raddr     = pos_calc;
      old_value     = filled_ff[pos_ff] ? ram_rdata : '0;
      readings_next = (readings_ff == COUNT_MAX) ? readings_ff : readings_ff + COUNT_W'(1);
      pos_plus      = LEN_W'(pos_ff) + LEN_W'(1);
      rem_shift     = {rem_ff, quo_ff[DIV_W-1]};

      // Drop the result once the receiver takes it
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Take a queued beat and start reading the entry to be replaced
            if (q_valid) begin
               q_pop       = 1'b1;
               item_in     = q_item;
               pos_in      = pos_calc;
               prev_idx_in = prev_calc;
               len_in      = len_clamped;
               state_in    = ST_OLD;
            end
         end
         ST_OLD: begin
            // Replace the entry, update the sum, counters and write position
            sum_in           = sum_ff - SUM_W'(old_value) + SUM_W'(item_ff.value);
            ram_we           = 1'b1;
            filled_in[pos_ff] = 1'b1;
            readings_in      = readings_next;
            if (readings_next > COUNT_W'(len_ff) && overwrites_ff != COUNT_MAX) begin
               overwrites_in = overwrites_ff + COUNT_W'(1);
            end
            wp_in     = (pos_plus >= len_ff) ? '0 : POS_W'(pos_plus);
            ram_raddr = prev_idx_ff;
            state_in  = ST_PREV;
         end
         ST_PREV: begin
            // Capture the neighbour entry and load the divider
            if (prev_idx_ff == pos_ff) begin
               prev_in = item_ff.value;
            end else begin
               prev_in = filled_ff[prev_idx_ff] ? ram_rdata : '0;
            end
            n_in     = (readings_ff < COUNT_W'(len_ff)) ? LEN_W'(readings_ff) : len_ff;
            rem_in   = '0;
            quo_in   = {sum_ff, {MEAN_FRAC{1'b0}}};
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // One quotient bit per cycle, restoring division
            if (rem_shift >= {1'b0, n_ff}) begin
               rem_in = LEN_W'(rem_shift - {1'b0, n_ff});
               quo_in = {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = LEN_W'(rem_shift);
               quo_in = {quo_ff[DIV_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the result register is free, then load it
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_cur_in   = item_ff.value;
               out_prev_in  = prev_ff;
               out_rd_in    = readings_ff;
               out_ow_in    = overwrites_ff;
               out_sum_in   = (32'(sum_ff) > SUM_OUT_MAX) ? SUM_OUT_W'(SUM_OUT_MAX)
                                                          : SUM_OUT_W'(sum_ff);
               out_mean_in  = (32'(quo_ff) > MEAN_MAX) ? MEAN_W'(MEAN_MAX)
                                                       : MEAN_W'(quo_ff);
               out_duty_in  = item_ff.duty;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wp_ff         <= '0;
         readings_ff   <= '0;
         overwrites_ff <= '0;
         sum_ff        <= '0;
         filled_ff     <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         readings_ff   <= readings_in;
         overwrites_ff <= overwrites_in;
         sum_ff        <= sum_in;
         filled_ff     <= filled_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      pos_ff      <= pos_in;
      prev_idx_ff <= prev_idx_in;
      len_ff      <= len_in;
      n_ff        <= n_in;
      prev_ff     <= prev_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      out_cur_ff  <= out_cur_in;
      out_prev_ff <= out_prev_in;
      out_rd_ff   <= out_rd_in;
      out_ow_ff   <= out_ow_in;
      out_sum_ff  <= out_sum_in;
      out_mean_ff <= out_mean_in;
      out_duty_ff <= out_duty_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_current_value   = out_cur_ff;
   assign rsp_previous_value  = out_prev_ff;
   assign rsp_reading_count   = out_rd_ff;
   assign rsp_overwrite_count = out_ow_ff;
   assign rsp_window_sum      = out_sum_ff;
   assign rsp_window_mean_q8  = out_mean_ff;
   assign rsp_pwm_duty        = out_duty_ff;

endmodule
